[hw/rtl/bba_pkg.sv]
// Shared types and constants for the bitmap block allocator.
`default_nettype none

package bba_pkg;

  localparam int MaxBlocks  = 4096;
  localparam int BlockBytes = 1024;
  localparam int InodeBytes = 128;

  localparam int WordBits = 64;
  localparam int MapWords = (MaxBlocks + WordBits - 1) / WordBits;
  localparam int RowW     = $clog2(MapWords);
  localparam int BitW     = $clog2(WordBits);
  localparam int BlockW   = RowW + BitW;
  localparam int CountW   = BlockW + 1;
  localparam int InodeW   = 11;
  localparam int InodeByteW = InodeW + $clog2(InodeBytes);
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] CFG_TOTAL_BLOCKS = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_TOTAL_INODES = 1'd1;

  localparam logic [CfgDataW-1:0] TotalBlocksReset = 13'd4096;
  localparam logic [InodeW-1:0]   TotalInodesReset = 11'd256;

  typedef enum logic [1:0] {
    OP_FORMAT  = 2'd0,
    OP_RESERVE = 2'd1,
    OP_FREE    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FORMAT,
    S_SCAN,
    S_FREE
  } state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [BlockW-1:0] block_number;
  } alloc_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [BlockW-1:0] granted_block;
    logic [CountW-1:0] free_count;
  } alloc_rsp_t;

  typedef struct packed {
    logic load;
    logic fmt_init;
    logic fmt_write;
    logic scan_init;
    logic scan_run;
    logic free_read;
    logic free_write;
    logic reply_plain;
    logic reply_nofree;
    logic reply_range;
  } bba_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic bn_oob;
    logic fmt_last;
    logic scan_hit;
    logic scan_miss;
  } bba_stat_t;

endpackage

`default_nettype wire

[hw/rtl/bitmap_block_allocator_core.sv]
// Top level of the bitmap block allocator: controller plus datapath.
`default_nettype none

// First-fit block allocator over a 4096-bit map held as 64 words of 64 bits
// in a single-port-write, registered-read memory. A command is taken when
// start is high and busy is low; its result word appears on rsp for one cycle
// with done high and cannot be held off. Unknown operations and immediate
// errors (no free block, block out of range) return in the cycle after accept.
// Free does one read-modify-write of its map word. Format writes max(1,
// ceil(used / 64)) map words, where used is the number of metadata blocks
// (one word write with the default sizes, at most five for any register
// value). Reserve scans one map word per cycle from word 0 behind the
// registered read. Map rows carry valid bits that reset and format clear at
// once, so no clearing pass is needed after reset. Config writes are always
// ready and must be issued only while the block is idle.
module bitmap_block_allocator_core import bba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  alloc_req_t          req,
  output logic                done,
  output alloc_rsp_t          rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  bba_cmd_t  cmd;
  bba_stat_t stat;

  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  bba_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

[hw/rtl/bba_ctrl.sv]
// Controller state machine for the bitmap block allocator.
`default_nettype none

module bba_ctrl import bba_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  alloc_req_t req,
  input  bba_stat_t  stat,
  output logic       busy,
  output bba_cmd_t   cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (op_t'(req.operation))
            OP_FORMAT:  state_next = S_FORMAT;
            OP_RESERVE: state_next = stat.count_zero ? S_IDLE : S_SCAN;
            OP_FREE:    state_next = stat.bn_oob ? S_IDLE : S_FREE;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_FORMAT: if (stat.fmt_last) state_next = S_IDLE;
      S_SCAN:   if (stat.scan_hit || stat.scan_miss) state_next = S_IDLE;
      S_FREE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (op_t'(req.operation))
            OP_FORMAT: cmd.fmt_init = 1'b1;
            OP_RESERVE: begin
              cmd.reply_nofree = stat.count_zero;
              cmd.scan_init    = !stat.count_zero;
            end
            OP_FREE: begin
              cmd.reply_range = stat.bn_oob;
              cmd.free_read   = !stat.bn_oob;
            end
            default: cmd.reply_plain = 1'b1;
          endcase
        end
      end
      S_FORMAT: begin
        cmd.fmt_write   = 1'b1;
        cmd.reply_plain = stat.fmt_last;
      end
      S_SCAN:  cmd.scan_run   = 1'b1;
      S_FREE:  cmd.free_write = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/bba_datapath.sv]
// Datapath: config registers, block map memory, free count and result register.
`default_nettype none

module bba_datapath import bba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  alloc_req_t          req,
  input  logic                cfg_valid,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  bba_cmd_t            cmd,
  output bba_stat_t           stat,
  output logic                done,
  output alloc_rsp_t          rsp
);

  logic [CfgDataW-1:0]   total_blocks;
  logic [InodeW-1:0]     total_inodes;
  logic [CountW-1:0]     free_blocks;
  logic [CountW-1:0]     dev_blocks;
  logic [CountW-1:0]     map_bytes;
  logic [CountW-1:0]     map_blks;
  logic [InodeByteW-1:0] inode_bytes;
  logic [CountW-1:0]     inode_blks;
  logic [CountW-1:0]     meta;

  logic [WordBits-1:0] map_mem [MapWords];
  logic [MapWords-1:0] row_valid;
  logic [WordBits-1:0] rd_word;
  logic                rd_row_valid;
  logic [WordBits-1:0] cur_word;
  logic [RowW-1:0]     raddr;

  logic                we;
  logic [RowW-1:0]     waddr;
  logic [WordBits-1:0] wdata;

  logic [BlockW-1:0] req_bn;
  logic [RowW-1:0]   fmt_ptr;
  logic [CountW-1:0] fmt_used;
  logic [CountW-1:0] fmt_base;
  logic [CountW-1:0] fmt_next_base;
  logic [WordBits-1:0] fmt_mask;

  logic [RowW-1:0]     scan_addr;
  logic [RowW-1:0]     chk_row;
  logic                chk_valid;
  logic [WordBits-1:0] zeros;
  logic                has_zero;
  logic [BitW-1:0]     zk;
  logic [CountW-1:0]   chk_base;
  logic [CountW-1:0]   chk_next_base;
  logic [BlockW-1:0]   hit_blk;
  logic                chk_in_range;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks <= TotalBlocksReset;
      total_inodes <= TotalInodesReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TOTAL_BLOCKS: total_blocks <= cfg_data;
        CFG_TOTAL_INODES: total_inodes <= cfg_data[InodeW-1:0];
        default: ;
      endcase
    end
  end

  assign dev_blocks = (total_blocks > CountW'(MaxBlocks)) ? CountW'(MaxBlocks) : total_blocks;

  // metadata size
  assign map_bytes   = dev_blocks >> 3;
  assign map_blks    = CountW'(map_bytes / BlockBytes)
                     + CountW'((map_bytes % BlockBytes) != 0);
  assign inode_bytes = InodeByteW'(total_inodes) * InodeByteW'(InodeBytes);
  assign inode_blks  = CountW'(inode_bytes / BlockBytes)
                     + CountW'((inode_bytes % BlockBytes) != 0);
  assign meta        = CountW'(1) + map_blks + inode_blks;

  // format row mask
  assign fmt_base      = CountW'({fmt_ptr, {BitW{1'b0}}});
  assign fmt_next_base = {(RowW + 1)'(fmt_ptr) + (RowW + 1)'(1), {BitW{1'b0}}};

  always_comb begin
    if (fmt_used >= fmt_next_base) begin
      fmt_mask = '1;
    end else if (fmt_used <= fmt_base) begin
      fmt_mask = '0;
    end else begin
      fmt_mask = ~({WordBits{1'b1}} << fmt_used[BitW-1:0]);
    end
  end

  // scan check stage
  assign cur_word = rd_row_valid ? rd_word : '0;
  assign zeros    = ~cur_word;
  assign has_zero = |zeros;

  always_comb begin
    zk = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (zeros[i]) zk = BitW'(i);
    end
  end

  assign chk_base      = CountW'({chk_row, {BitW{1'b0}}});
  assign chk_next_base = {(RowW + 1)'(chk_row) + (RowW + 1)'(1), {BitW{1'b0}}};
  assign hit_blk       = {chk_row, zk};
  assign chk_in_range  = chk_base < dev_blocks;

  assign stat.count_zero = (free_blocks == '0);
  assign stat.bn_oob     = CountW'(req.block_number) >= dev_blocks;
  assign stat.fmt_last   = fmt_next_base >= fmt_used;
  assign stat.scan_hit   = chk_valid && chk_in_range && has_zero
                         && (CountW'(hit_blk) < dev_blocks);
  assign stat.scan_miss  = chk_valid && !stat.scan_hit
                         && (!chk_in_range || has_zero || (chk_next_base >= dev_blocks));

  // memory port
  assign raddr = cmd.free_read ? req.block_number[BlockW-1:BitW] : scan_addr;

  always_comb begin
    we    = 1'b0;
    waddr = fmt_ptr;
    wdata = fmt_mask;
    if (cmd.fmt_write) begin
      we = 1'b1;
    end else if (cmd.scan_run && stat.scan_hit) begin
      we    = 1'b1;
      waddr = chk_row;
      wdata = cur_word | (WordBits'(1) << zk);
    end else if (cmd.free_write) begin
      we    = 1'b1;
      waddr = req_bn[BlockW-1:BitW];
      wdata = cur_word & ~(WordBits'(1) << req_bn[BitW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      map_mem[waddr] <= wdata;
    end
    rd_word <= map_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.fmt_init) begin
      row_valid <= '0;
    end else if (we) begin
      row_valid[waddr] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_row_valid <= row_valid[raddr];
    if (cmd.load) begin
      req_bn <= req.block_number;
    end
    if (cmd.fmt_init) begin
      fmt_ptr  <= '0;
      fmt_used <= (meta > dev_blocks) ? dev_blocks : meta;
    end else if (cmd.fmt_write) begin
      fmt_ptr <= fmt_ptr + RowW'(1);
    end
    if (cmd.scan_init) begin
      scan_addr <= '0;
    end else if (cmd.scan_run) begin
      scan_addr <= scan_addr + RowW'(1);
      chk_row   <= scan_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (cmd.scan_init) begin
      chk_valid <= 1'b0;
    end else if (cmd.scan_run) begin
      chk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_blocks <= '0;
    end else if (cmd.fmt_init) begin
      free_blocks <= (dev_blocks > meta) ? (dev_blocks - meta) : '0;
    end else if (cmd.scan_run && stat.scan_hit) begin
      free_blocks <= free_blocks - CountW'(1);
    end else if (cmd.free_write && (free_blocks < dev_blocks)) begin
      free_blocks <= free_blocks + CountW'(1);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.reply_plain || cmd.reply_nofree || cmd.reply_range || cmd.free_write
           || (cmd.scan_run && (stat.scan_hit || stat.scan_miss));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reply_plain) begin
      rsp.status        <= ST_OK;
      rsp.granted_block <= '0;
      rsp.free_count    <= free_blocks;
    end else if (cmd.reply_nofree || (cmd.scan_run && stat.scan_miss)) begin
      rsp.status        <= ST_NO_FREE;
      rsp.granted_block <= '0;
      rsp.free_count    <= free_blocks;
    end else if (cmd.reply_range) begin
      rsp.status        <= ST_RANGE;
      rsp.granted_block <= '0;
      rsp.free_count    <= free_blocks;
    end else if (cmd.scan_run && stat.scan_hit) begin
      rsp.status        <= ST_OK;
      rsp.granted_block <= hit_blk;
      rsp.free_count    <= free_blocks - CountW'(1);
    end else if (cmd.free_write) begin
      rsp.status        <= ST_OK;
      rsp.granted_block <= req_bn;
      rsp.free_count    <= (free_blocks < dev_blocks) ? free_blocks + CountW'(1) : free_blocks;
    end else begin
      rsp.free_count    <= free_blocks;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_blocks <= CountW'(MaxBlocks))
    else $error("free count above map size");

  a_hit_decrements: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_run && stat.scan_hit) |=> (free_blocks == $past(free_blocks) - CountW'(1)))
    else $error("reserve hit did not decrement count");

  a_hit_reply: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_run && stat.scan_hit) |=> (done && rsp.status == ST_OK))
    else $error("reserve hit without ok result");

  a_miss_reply: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_run && stat.scan_miss) |=> (done && rsp.granted_block == '0))
    else $error("reserve miss with nonzero block");

endmodule

`default_nettype wire
